// ----- sv/dhlt_pkg.sv -----
// shared types, constants and tables for the dh link transform
package dhlt_pkg;

  localparam int AngleW   = 17;
  localparam int ValueW   = 32;
  localparam int AngleTurn = 46080;
  localparam int AngleQuad = 11520;
  localparam int ZW       = 36;
  localparam int XW       = 34;
  localparam logic signed [XW-1:0] CordicGain = 34'sd652032874;

  // arctangent of 2^-i as a fraction of a full turn (2^32 per turn)
  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    logic signed [ZW-1:0] t;
    begin
      case (i)
        0: t = 36'sd536870912;  1: t = 36'sd316933406;
        2: t = 36'sd167458907;  3: t = 36'sd85004756;
        4: t = 36'sd42667331;   5: t = 36'sd21354465;
        6: t = 36'sd10679838;   7: t = 36'sd5340245;
        8: t = 36'sd2670163;    9: t = 36'sd1335087;
        10: t = 36'sd667544;    11: t = 36'sd333772;
        12: t = 36'sd166886;    13: t = 36'sd83443;
        14: t = 36'sd41722;     15: t = 36'sd20861;
        16: t = 36'sd10430;     17: t = 36'sd5215;
        18: t = 36'sd2608;      19: t = 36'sd1304;
        20: t = 36'sd652;       21: t = 36'sd326;
        22: t = 36'sd163;       23: t = 36'sd81;
        24: t = 36'sd41;        25: t = 36'sd20;
        26: t = 36'sd10;        27: t = 36'sd5;
        28: t = 36'sd3;         29: t = 36'sd1;
        30: t = 36'sd1;
        default: t = '0;
      endcase
      return t;
    end
  endfunction

  // saturate a wide signed value to 32 bits
  function automatic logic signed [ValueW-1:0] sat32(input logic signed [65:0] v);
    logic signed [ValueW-1:0] r;
    begin
      if (v > 66'sd2147483647) r = 32'sh7fffffff;
      else if (v < -66'sd2147483648) r = 32'sh80000000;
      else r = v[ValueW-1:0];
      return r;
    end
  endfunction

  // cordic stage payload
  typedef struct packed {
    logic signed [XW-1:0] xa;
    logic signed [XW-1:0] ya;
    logic signed [ZW-1:0] za;
    logic signed [XW-1:0] xt;
    logic signed [XW-1:0] yt;
    logic signed [ZW-1:0] zt;
    logic [1:0]           qa;
    logic [1:0]           qt;
    logic signed [ValueW-1:0] a;
    logic signed [ValueW-1:0] d;
  } cordic_t;

endpackage

// ----- sv/dhlt_reduce.sv -----
// angle reduction to quadrant and turn units, two register stages
module dhlt_reduce (
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  logic in_valid,
  input  logic signed [dhlt_pkg::AngleW-1:0] twist_angle,
  input  logic signed [dhlt_pkg::AngleW-1:0] joint_angle,
  input  logic signed [dhlt_pkg::ValueW-1:0] link_length,
  input  logic signed [dhlt_pkg::ValueW-1:0] link_offset,
  output logic out_valid,
  output dhlt_pkg::cordic_t out_data
);

  // stage 1 registers: reduced angle in [0, 46080)
  logic        v1;
  logic [15:0] ra, rt;
  logic signed [dhlt_pkg::ValueW-1:0] a1, d1;

  // fold a 17-bit signed angle into one turn (|ang| <= 65536 < 2 turns)
  function automatic logic [15:0] fold(input logic signed [dhlt_pkg::AngleW-1:0] ang);
    logic signed [18:0] s;
    logic signed [18:0] t;
    begin
      s = 19'(ang);
      t = 19'(dhlt_pkg::AngleTurn);
      if (s < 0) s = s + t;
      if (s < 0) s = s + t;
      if (s >= t) s = s - t;
      return s[15:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
    end
    if (advance) begin
      ra <= fold(twist_angle);
      rt <= fold(joint_angle);
      a1 <= link_length;
      d1 <= link_offset;
    end
  end

  // quadrant split and turn conversion: round(f * 2^32 / 46080)
  function automatic logic [1:0] quad(input logic [15:0] r);
    begin
      if (r >= 16'(3 * dhlt_pkg::AngleQuad)) return 2'd3;
      else if (r >= 16'(2 * dhlt_pkg::AngleQuad)) return 2'd2;
      else if (r >= 16'(dhlt_pkg::AngleQuad)) return 2'd1;
      else return 2'd0;
    end
  endfunction

  function automatic logic signed [dhlt_pkg::ZW-1:0] to_turn(input logic [15:0] r,
                                                             input logic [1:0] q);
    logic [13:0] f;
    logic [19:0] n;
    logic [40:0] nq;
    logic [31:0] hi;
    begin
      f = 14'(r - 16'(32'(q) * dhlt_pkg::AngleQuad));
      // round(f*2^23/90) = floor((f*2^23 + 45) / 90)
      // with 2^22 = 45*93206 + 34 this is f*93206 + floor((68*f + 45) / 90)
      // the small quotient uses a reciprocal: floor(n*1491309 / 2^27) for n < 2^20
      n  = 20'(f) * 20'd68 + 20'd45;
      nq = 41'(n) * 41'd1491309;
      hi = 32'(f) * 32'd93206;
      return dhlt_pkg::ZW'(hi) + dhlt_pkg::ZW'(nq[40:27]);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v1;
    end
    if (advance) begin
      out_data.xa <= dhlt_pkg::CordicGain;
      out_data.ya <= '0;
      out_data.za <= to_turn(ra, quad(ra));
      out_data.qa <= quad(ra);
      out_data.xt <= dhlt_pkg::CordicGain;
      out_data.yt <= '0;
      out_data.zt <= to_turn(rt, quad(rt));
      out_data.qt <= quad(rt);
      out_data.a  <= a1;
      out_data.d  <= d1;
    end
  end

endmodule

// ----- sv/dhlt_cordic.sv -----
// pipelined rotation cordic, one stage per iteration, both angles in parallel
module dhlt_cordic #(
  parameter int CORDIC_STAGES = 20
) (
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  logic in_valid,
  input  dhlt_pkg::cordic_t in_data,
  output logic out_valid,
  output dhlt_pkg::cordic_t out_data
);

  localparam int N = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  logic              vld [N+1];
  dhlt_pkg::cordic_t stg [N+1];

  assign vld[0] = in_valid;
  assign stg[0] = in_data;

  for (genvar i = 0; i < N; i++) begin : g_stage
    dhlt_pkg::cordic_t nxt;
    // one micro-rotation on each angle
    always_comb begin
      nxt = stg[i];
      if (stg[i].za >= 0) begin
        nxt.xa = stg[i].xa - (stg[i].ya >>> i);
        nxt.ya = stg[i].ya + (stg[i].xa >>> i);
        nxt.za = stg[i].za - dhlt_pkg::atan_turn(i);
      end else begin
        nxt.xa = stg[i].xa + (stg[i].ya >>> i);
        nxt.ya = stg[i].ya - (stg[i].xa >>> i);
        nxt.za = stg[i].za + dhlt_pkg::atan_turn(i);
      end
      if (stg[i].zt >= 0) begin
        nxt.xt = stg[i].xt - (stg[i].yt >>> i);
        nxt.yt = stg[i].yt + (stg[i].xt >>> i);
        nxt.zt = stg[i].zt - dhlt_pkg::atan_turn(i);
      end else begin
        nxt.xt = stg[i].xt + (stg[i].yt >>> i);
        nxt.yt = stg[i].yt - (stg[i].xt >>> i);
        nxt.zt = stg[i].zt + dhlt_pkg::atan_turn(i);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (advance) begin
        vld[i+1] <= vld[i];
      end
      if (advance) begin
        stg[i+1] <= nxt;
      end
    end
  end

  assign out_valid = vld[N];
  assign out_data  = stg[N];

endmodule

// ----- sv/dhlt_matrix.sv -----
// sine/cosine rounding, quadrant swap, products and row sequencing
module dhlt_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  dhlt_pkg::cordic_t in_data,
  output logic in_stall,
  output logic valid,
  input  logic stall,
  output logic [1:0] row_index,
  output logic signed [dhlt_pkg::ValueW-1:0] col0_value,
  output logic signed [dhlt_pkg::ValueW-1:0] col1_value,
  output logic signed [dhlt_pkg::ValueW-1:0] col2_value,
  output logic signed [dhlt_pkg::ValueW-1:0] col3_value,
  output logic last_row
);

  localparam int Sh = 30 - FRAC_BITS;
  localparam int SW = FRAC_BITS + 3;
  localparam logic signed [dhlt_pkg::ValueW-1:0] One =
    dhlt_pkg::ValueW'(64'd1 << FRAC_BITS);

  // stage A advances when it is empty or stage B can take its item
  logic advance;
  logic va, vb;
  logic [1:0] row;

  // round q30 to fixed point, then swap by quadrant
  function automatic logic signed [SW-1:0] rnd(input logic signed [dhlt_pkg::XW-1:0] v);
    logic signed [dhlt_pkg::XW:0] t;
    begin
      t = (dhlt_pkg::XW+1)'(v) + ((dhlt_pkg::XW+1)'(1) <<< (Sh - 1));
      t = t >>> Sh;
      return SW'(t);
    end
  endfunction

  logic signed [SW-1:0] cfa, sfa, cft, sft;
  logic signed [SW-1:0] sa, ca, st, ct;
  logic signed [SW-1:0] sa_n, ca_n, st_n, ct_n;
  logic signed [dhlt_pkg::ValueW-1:0] a_r, d_r;

  always_comb begin
    cfa = rnd(in_data.xa);
    sfa = rnd(in_data.ya);
    cft = rnd(in_data.xt);
    sft = rnd(in_data.yt);
    case (in_data.qa)
      2'd0: begin ca_n = cfa;  sa_n = sfa;  end
      2'd1: begin ca_n = -sfa; sa_n = cfa;  end
      2'd2: begin ca_n = -cfa; sa_n = -sfa; end
      default: begin ca_n = sfa; sa_n = -cfa; end
    endcase
    case (in_data.qt)
      2'd0: begin ct_n = cft;  st_n = sft;  end
      2'd1: begin ct_n = -sft; st_n = cft;  end
      2'd2: begin ct_n = -cft; st_n = -sft; end
      default: begin ct_n = sft; st_n = -cft; end
    endcase
  end

  // stage B holds one item while its four rows go out
  logic b_free;
  assign b_free   = !vb || (row == 2'd3 && !stall);
  assign advance  = !va || b_free;
  assign in_stall = !advance;
  assign valid    = vb;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (advance) begin
      va <= in_valid;
    end
    if (advance) begin
      sa <= sa_n; ca <= ca_n; st <= st_n; ct <= ct_n;
      a_r <= in_data.a; d_r <= in_data.d;
    end
  end

  // products, one multiplier each, registered
  function automatic logic signed [dhlt_pkg::ValueW-1:0] fmul(
      input logic signed [dhlt_pkg::ValueW-1:0] x, input logic signed [SW-1:0] y);
    logic signed [65:0] p;
    begin
      p = 66'(x) * 66'(y);
      p = (p + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return dhlt_pkg::sat32(p);
    end
  endfunction

  logic signed [dhlt_pkg::ValueW-1:0] m10, m11, m13, m20, m21, m23;
  logic signed [dhlt_pkg::ValueW-1:0] b_ct, b_st, b_sa, b_ca, b_a;
  logic signed [dhlt_pkg::ValueW-1:0] neg13;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (b_free) begin
      vb <= va;
    end
    if (b_free && va) begin
      m10 <= fmul(32'(st), ca);
      m11 <= fmul(32'(ct), ca);
      m20 <= fmul(32'(st), sa);
      m21 <= fmul(32'(ct), sa);
      m13 <= fmul(d_r, sa);
      m23 <= fmul(d_r, ca);
      b_ct <= 32'(ct); b_st <= 32'(st); b_sa <= 32'(sa); b_ca <= 32'(ca);
      b_a <= a_r;
    end
  end

  assign neg13 = (m13 == 32'sh80000000) ? 32'sh7fffffff : -m13;

  // row counter, one row per cycle while stage B holds an item and the output is not stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= 2'd0;
    end else if (vb && !stall) begin
      row <= row + 2'd1;
    end
  end

  always_comb begin
    row_index = row;
    last_row  = (row == 2'd3);
    case (row)
      2'd0: begin col0_value = b_ct; col1_value = -b_st; col2_value = '0;     col3_value = b_a;  end
      2'd1: begin col0_value = m10;  col1_value = m11;   col2_value = -b_sa;  col3_value = neg13; end
      2'd2: begin col0_value = m20;  col1_value = m21;   col2_value = b_ca;   col3_value = m23;  end
      default: begin col0_value = '0; col1_value = '0;   col2_value = '0;     col3_value = One;  end
    endcase
  end

  // a row index only counts forward while a row is shown
  assert property (@(posedge clk) disable iff (rst)
    valid && stall |=> $stable(row)) else $error("row moved under stall");
  assert property (@(posedge clk) disable iff (rst)
    valid && !stall && row == 2'd3 |=> row == 2'd0) else $error("row wrap");
  assert property (@(posedge clk) disable iff (rst)
    valid |-> vb) else $error("row shown without item");

endmodule

// ----- sv/dh_link_transform.sv -----
// top level: modified dh link transform, four matrix rows per request
//
// channel | signals                                          | direction
// input   | in_valid, in_stall, twist/joint angle, link len/off | request in
// output  | valid, stall, row_index, col0..col3_value, last_row | rows out
//
// an item passes reduce, cordic and matrix stages A and B before its first row
// each request yields four rows, one per cycle unless the output stalls
// the row sequencer holding one item paces requests; the cordic is fully pipelined
// rst is synchronous and clears only valid bits and the row counter
// a stall holds stage B, upstream stops if A is full; nothing is lost or repeated
module dh_link_transform #(
  parameter int CORDIC_STAGES = 20,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [16:0] twist_angle,
  input  logic signed [16:0] joint_angle,
  input  logic signed [31:0] link_length,
  input  logic signed [31:0] link_offset,
  output logic valid,
  input  logic stall,
  output logic [1:0] row_index,
  output logic signed [31:0] col0_value,
  output logic signed [31:0] col1_value,
  output logic signed [31:0] col2_value,
  output logic signed [31:0] col3_value,
  output logic last_row
);

  logic advance;
  logic r_valid, c_valid;
  dhlt_pkg::cordic_t r_data, c_data;

  // front stages move together with matrix stage A
  assign advance = !in_stall;

  dhlt_reduce u_reduce (
    .clk, .rst, .advance, .in_valid,
    .twist_angle, .joint_angle, .link_length, .link_offset,
    .out_valid(r_valid), .out_data(r_data)
  );

  dhlt_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk, .rst, .advance,
    .in_valid(r_valid), .in_data(r_data),
    .out_valid(c_valid), .out_data(c_data)
  );

  dhlt_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk, .rst,
    .in_valid(c_valid), .in_data(c_data), .in_stall,
    .valid, .stall, .row_index,
    .col0_value, .col1_value, .col2_value, .col3_value, .last_row
  );

endmodule

// ----- dv/tb.sv -----
// testbench for dh_link_transform: queued requests, predicted matrix rows, row-by-row check
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Stages = 20;
  localparam int Frac = 16;
  localparam int Latency = 3 + Stages + 2 + 8;
  localparam longint CycleLimit = 400000;

  typedef struct {
    logic signed [16:0] twist;
    logic signed [16:0] joint;
    logic signed [31:0] len;
    logic signed [31:0] off;
  } link_req_t;

  typedef struct {
    logic [1:0] row;
    logic signed [31:0] c0, c1, c2, c3;
    logic last;
  } mat_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [16:0] twist_angle = '0;
  logic signed [16:0] joint_angle = '0;
  logic signed [31:0] link_length = '0;
  logic signed [31:0] link_offset = '0;
  logic valid;
  logic stall = 1'b0;
  logic [1:0] row_index;
  logic signed [31:0] col0_value, col1_value, col2_value, col3_value;
  logic last_row;

  link_req_t pending_reqs[$];
  mat_row_t expected_rows[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  bit send_pause = 1'b0;
  longint cycles = 0;

  dh_link_transform #(.CORDIC_STAGES(Stages), .FRAC_BITS(Frac)) u_top (.*);

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // floor division by a power of two
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_q(longint v, int s);
    return floor_shift(v + (longint'(1) <<< (s - 1)), s);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint x, longint y);
    return clamp32(round_q(x * y, Frac));
  endfunction

  // cordic sine and cosine of an angle in 1/128 degree
  task automatic angle_sin_cos(input int ang, output longint s, output longint c);
    int r, q, f;
    longint x, y, z, nx, ny, cf, sf;
    r = ang % dhlt_pkg::AngleTurn;
    if (r < 0) r += dhlt_pkg::AngleTurn;
    q = r / dhlt_pkg::AngleQuad;
    f = r - q * dhlt_pkg::AngleQuad;
    z = ((longint'(f) <<< 32) + dhlt_pkg::AngleTurn / 2) / dhlt_pkg::AngleTurn;
    x = 652032874;
    y = 0;
    for (int i = 0; i < Stages; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        ny = y + floor_shift(x, i);
        z -= longint'(dhlt_pkg::atan_turn(i));
      end else begin
        nx = x + floor_shift(y, i);
        ny = y - floor_shift(x, i);
        z += longint'(dhlt_pkg::atan_turn(i));
      end
      x = nx;
      y = ny;
    end
    cf = round_q(x, 30 - Frac);
    sf = round_q(y, 30 - Frac);
    case (q)
      0: begin c = cf; s = sf; end
      1: begin c = -sf; s = cf; end
      2: begin c = -cf; s = -sf; end
      default: begin c = sf; s = -cf; end
    endcase
  endtask

  // predict the four rows of the link transform
  task automatic predict_transform(input link_req_t rq);
    longint sa, ca, st, ct, a, d;
    longint m[4][4];
    mat_row_t r;
    angle_sin_cos(int'(rq.twist), sa, ca);
    angle_sin_cos(int'(rq.joint), st, ct);
    a = rq.len;
    d = rq.off;
    m[0][0] = ct; m[0][1] = -st; m[0][2] = 0; m[0][3] = a;
    m[1][0] = qmul(st, ca); m[1][1] = qmul(ct, ca); m[1][2] = -sa;
    m[1][3] = clamp32(-qmul(d, sa));
    m[2][0] = qmul(st, sa); m[2][1] = qmul(ct, sa); m[2][2] = ca;
    m[2][3] = qmul(d, ca);
    m[3][0] = 0; m[3][1] = 0; m[3][2] = 0; m[3][3] = longint'(1) <<< Frac;
    for (int k = 0; k < 4; k++) begin
      r.row = k[1:0];
      r.c0 = clamp32(m[k][0]);
      r.c1 = clamp32(m[k][1]);
      r.c2 = clamp32(m[k][2]);
      r.c3 = clamp32(m[k][3]);
      r.last = (k == 3);
      expected_rows.push_back(r);
    end
  endtask

  function automatic logic signed [16:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 17'($urandom);
      1: return 17'(int'($urandom_range(0, 8)) * dhlt_pkg::AngleQuad / 2 -
                    dhlt_pkg::AngleTurn * ($urandom_range(0, 1)));
      default: return 17'(int'($urandom_range(0, 2 * dhlt_pkg::AngleTurn)) -
                          dhlt_pkg::AngleTurn);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_len();
    case ($urandom_range(0, 4))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'($urandom_range(0, 200000)) - 32'sd100000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_req(int tw, int jt, logic [31:0] a, logic [31:0] d);
    link_req_t rq;
    rq.twist = 17'(tw);
    rq.joint = 17'(jt);
    rq.len = a;
    rq.off = d;
    pending_reqs.push_back(rq);
  endtask

  // request driver
  always @(posedge clk) begin
    link_req_t rq;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_reqs.size() > 0 && !send_pause &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        rq = pending_reqs.pop_front();
        predict_transform(rq);
        in_valid <= 1'b1;
        twist_angle <= rq.twist;
        joint_angle <= rq.joint;
        link_length <= rq.len;
        link_offset <= rq.off;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (hold_off > 0) begin
      stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // row monitor
  always @(posedge clk) begin
    mat_row_t e;
    if (!rst && valid && !stall) begin
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected row %0d", row_index);
      end else begin
        e = expected_rows.pop_front();
        if (row_index !== e.row || col0_value !== e.c0 || col1_value !== e.c1 ||
            col2_value !== e.c2 || col3_value !== e.c3 || last_row !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("row mismatch exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                     e.row, e.c0, e.c1, e.c2, e.c3, e.last, row_index, col0_value,
                     col1_value, col2_value, col3_value, last_row);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_rows.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int a_list[8];
    a_list = '{0, 5760, 11520, 23040, 34560, 46080, -46080, -11520};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: quadrant edges, field extremes, out-of-range angles
    foreach (a_list[i]) queue_req(a_list[i], a_list[7 - i], 32'h0001_0000, 32'h0002_0000);
    queue_req(65535, -65536, 32'h7fffffff, 32'h80000000);
    queue_req(-65536, 65535, 32'h80000000, 32'h7fffffff);
    queue_req(5760, 17280, 32'h80000000, 32'h80000000);
    queue_req(28800, 40320, 32'h7fffffff, 32'h7fffffff);
    queue_req(1, -1, 32'hffffffff, 32'h00000001);
    queue_req(11519, 11521, 32'h0, 32'h0);
    queue_req(46079, -46079, 32'h5555aaaa, 32'haaaa5555);
    queue_req(-23040, 23040, 32'h7fffffff, 32'h80000001);
    drain();

    // random phases with varied idling
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 64 : (ph == 3) ? 30 : 0;
      recv_stall_pct = (ph == 2) ? 64 : (ph == 3) ? 30 : 0;
      for (int n = 0; n < 60; n++)
        queue_req(rand_angle(), rand_angle(), rand_len(), rand_len());
      if (ph == 0) hold_off = 300;
      drain();
    end

    // sender pause until all rows out, then a final burst
    send_pause = 1'b1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int n = 0; n < 20; n++) queue_req(rand_angle(), rand_angle(), rand_len(), rand_len());
    drain_wait: while (expected_rows.size() > 0) @(posedge clk);
    send_pause = 1'b0;
    drain();
    repeat (Latency) @(posedge clk);

    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
